### hdl/tbmc_pkg.sv
`timescale 1ns / 1ps
// Package for the token-bounded match counter: field widths, register map,
// opcodes, delimiter codes and the beat type. No dependencies.
package tbmc_pkg;

  localparam int DEF_MAX_QUERY  = 32;
  localparam int DEF_COUNT_BITS = 32;

  localparam int QLEN_W  = 6;    // query_length register width
  localparam int QWORDS  = 4;    // 64-bit query byte registers
  localparam int QBYTES  = 32;   // bytes held by the query registers
  localparam int DATA_W  = 64;   // APB data width
  localparam int ADDR_W  = 6;    // five registers at 8-byte stride
  localparam int OUT_W   = 32;   // match_count width
  localparam int IDX_W   = 3;    // register index bits, paddr[5:3]

  // register indexes
  localparam logic [IDX_W-1:0] REG_QLEN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_QLOW   = 3'd1;
  localparam logic [IDX_W-1:0] REG_QSEC   = 3'd2;
  localparam logic [IDX_W-1:0] REG_QTHIRD = 3'd3;
  localparam logic [IDX_W-1:0] REG_QHIGH  = 3'd4;

  // opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COLON) ||
           (c == CH_EQ) || (c == CH_COMMA) || (c == CH_LBRK) || (c == CH_RBRK);
  endfunction

endpackage

### hdl/tbmc_cfg.sv
`timescale 1ns / 1ps
// APB register file for the query, plus the query aligned to window order.
// Depends on tbmc_pkg.
module tbmc_cfg import tbmc_pkg::*; #(
  parameter int MAX_QUERY = DEF_MAX_QUERY,
  parameter int LEN_W     = $clog2(MAX_QUERY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic [LEN_W-1:0]  eff_len,
  output logic [7:0]        aq [MAX_QUERY],
  output logic [MAX_QUERY-1:0] qmask
);

  logic [QLEN_W-1:0]   query_length;
  logic [DATA_W-1:0]   qwords [QWORDS];
  logic [QBYTES*8-1:0] qflat;
  logic [IDX_W-1:0]    idx;

  assign idx = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      query_length <= '0;
      for (int w = 0; w < QWORDS; w++) qwords[w] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_QLEN:   query_length <= pwdata[QLEN_W-1:0];
        REG_QLOW:   qwords[0] <= pwdata;
        REG_QSEC:   qwords[1] <= pwdata;
        REG_QTHIRD: qwords[2] <= pwdata;
        REG_QHIGH:  qwords[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QLEN:   prdata = DATA_W'(query_length);
      REG_QLOW:   prdata = qwords[0];
      REG_QSEC:   prdata = qwords[1];
      REG_QTHIRD: prdata = qwords[2];
      REG_QHIGH:  prdata = qwords[3];
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    for (int w = 0; w < QWORDS; w++) qflat[w*DATA_W +: DATA_W] = qwords[w];
  end

  assign eff_len = (query_length > QLEN_W'(MAX_QUERY)) ? LEN_W'(MAX_QUERY)
                                                      : LEN_W'(query_length);

  // window slot p (0 = newest) must hold query byte eff_len-1-p
  always_comb begin
    logic [QLEN_W-1:0] k;
    for (int p = 0; p < MAX_QUERY; p++) begin
      k = QLEN_W'(eff_len) - QLEN_W'(p) - QLEN_W'(1);
      qmask[p] = QLEN_W'(p) < QLEN_W'(eff_len);
      // bytes past the register file read as zero, which never matches content
      if (qmask[p] && !k[QLEN_W-1]) aq[p] = qflat[{k[4:0], 3'b000} +: 8];
      else                          aq[p] = '0;
    end
  end

endmodule

### hdl/tbmc_match.sv
`timescale 1ns / 1ps
// Line window, fill count, stop flag and running total; bounded match check.
// Depends on tbmc_pkg.
module tbmc_match import tbmc_pkg::*; #(
  parameter int MAX_QUERY  = DEF_MAX_QUERY,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int LEN_W      = $clog2(MAX_QUERY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  item_t                item,
  input  logic [LEN_W-1:0]     eff_len,
  input  logic [7:0]           aq [MAX_QUERY],
  input  logic [MAX_QUERY-1:0] qmask,
  output logic [OUT_W-1:0]     count_now
);

  localparam int FILL_W = $clog2(MAX_QUERY + 2);
  localparam int WIDE_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

  logic [7:0]            window [MAX_QUERY+1];
  logic                  dflag  [MAX_QUERY+1];
  logic [FILL_W-1:0]     line_fill;
  logic                  line_stopped;
  logic [COUNT_BITS-1:0] running_total;

  logic                  all_eq;
  logic                  hit;
  logic                  do_check;
  logic                  shift_in;
  logic [COUNT_BITS-1:0] total_inc;
  logic [WIDE_W-1:0]     tot_ext;

  always_comb begin
    all_eq = 1'b1;
    for (int p = 0; p < MAX_QUERY; p++)
      if (qmask[p] && (window[p] != aq[p])) all_eq = 1'b0;
  end

  // left boundary: line start, or a delimiter just before the candidate
  assign hit = (eff_len != '0) && (line_fill >= FILL_W'(eff_len)) &&
               ((line_fill == FILL_W'(eff_len)) || dflag[eff_len]) && all_eq;

  assign do_check = !line_stopped &&
                    ((item.op == OP_END) || (item.data_byte == CH_NL) ||
                     is_delim(item.data_byte));
  assign shift_in = (item.op == OP_BYTE) && !line_stopped &&
                    (item.data_byte != CH_NL) && (item.data_byte != CH_NUL);

  assign total_inc = (do_check && hit && (running_total != '1)) ? running_total + 1'b1
                                                               : running_total;

  assign tot_ext   = WIDE_W'(total_inc);
  assign count_now = (tot_ext > WIDE_W'({OUT_W{1'b1}})) ? '1 : tot_ext[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill     <= '0;
      line_stopped  <= 1'b0;
      running_total <= '0;
    end else if (advance) begin
      if (item.op == OP_END) begin
        line_fill     <= '0;
        line_stopped  <= 1'b0;
        running_total <= '0;
      end else if (item.data_byte == CH_NL) begin
        line_fill     <= '0;
        line_stopped  <= 1'b0;
        running_total <= total_inc;
      end else if (!line_stopped) begin
        running_total <= total_inc;
        if (item.data_byte == CH_NUL) line_stopped <= 1'b1;
        else if (line_fill != FILL_W'(MAX_QUERY + 1)) line_fill <= line_fill + 1'b1;
      end
    end
  end

  // slots at or past line_fill are never looked at, so no clearing needed
  always_ff @(posedge clk) begin
    if (advance && shift_in) begin
      window[0] <= item.data_byte;
      dflag[0]  <= is_delim(item.data_byte);
      for (int i = 1; i <= MAX_QUERY; i++) begin
        window[i] <= window[i-1];
        dflag[i]  <= dflag[i-1];
      end
    end
  end

endmodule

### hdl/token_bounded_match_counter_unit.sv
`timescale 1ns / 1ps
// Whole-token query counter over a byte-streamed log: top level with the
// input beat register and the result register. Depends on tbmc_pkg,
// tbmc_cfg and tbmc_match.
//
// Input channel (in_valid/in_ready, op, data_byte): op 0 carries one log byte,
// newline closes a line; op 1 marks end of log. Only end-of-log beats produce
// a result on the output channel (out_valid/out_ready, match_count): the
// number of query occurrences bounded by delimiters or line edges, saturating.
// The query is set through the APB port before a log is streamed: register 0
// is the length, registers 1..4 the query bytes, at byte address 8*index.
// Throughput: one beat per cycle, unless an end-of-log beat waits on a full result
// register; every beat is folded into the line window and the count straight
// from the input register. A result is registered as its end-of-log beat leaves it.
// When the receiver stalls, the result register holds; log bytes keep flowing,
// and only a second end-of-log beat waits in the input register.
// Reset (rst, synchronous) clears the query, the line state and the count,
// and empties both registers; in_ready is low while rst is high.
module token_bounded_match_counter_unit import tbmc_pkg::*; #(
  parameter int MAX_QUERY  = DEF_MAX_QUERY,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  match_count
);

  localparam int LEN_W = $clog2(MAX_QUERY + 1);

  logic                 in_q_valid;
  item_t                in_q;
  logic                 advance;
  logic [LEN_W-1:0]     eff_len;
  logic [7:0]           aq [MAX_QUERY];
  logic [MAX_QUERY-1:0] qmask;
  logic [OUT_W-1:0]     count_now;

  assign pready = 1'b1;

  tbmc_cfg #(.MAX_QUERY(MAX_QUERY), .LEN_W(LEN_W)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .eff_len, .aq, .qmask
  );

  tbmc_match #(.MAX_QUERY(MAX_QUERY), .COUNT_BITS(COUNT_BITS), .LEN_W(LEN_W)) u_match (
    .clk, .rst, .advance, .item(in_q), .eff_len, .aq, .qmask, .count_now
  );

  // an end-of-log beat waits only if the result register is still full
  assign advance  = in_q_valid && ((in_q.op != OP_END) || !out_valid || out_ready);
  assign in_ready = !rst && (!in_q_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.op        <= op;
      in_q.data_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_q.op == OP_END)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_q.op == OP_END)) match_count <= count_now;
  end

`ifndef SYNTHESIS
  a_end_waits: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && (in_q.op == OP_END) && out_valid && !out_ready) |-> !in_ready)
    else $error("end-of-log beat taken over a stalled result");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_q.op == OP_END)) |=> out_valid)
    else $error("end-of-log beat produced no result");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && (in_q.op == OP_END)))
    else $error("result without an end-of-log beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_q_valid))
    else $error("registers not emptied by reset");
`endif

endmodule

### tb/sv/tb_token_bounded_match_counter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for token_bounded_match_counter_unit: streams logs of
// query tokens, delimiters, newlines, NULs and noise, and checks every count.
// Depends on tbmc_pkg and the RTL of the unit.
module tb_token_bounded_match_counter_unit;
  import tbmc_pkg::*;

  localparam int MAXQ      = DEF_MAX_QUERY;
  localparam int WIN_DEPTH = DEF_MAX_QUERY + 1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              op = OP_BYTE;
  logic [7:0]        data_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OUT_W-1:0]  match_count;

  token_bounded_match_counter_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready), .match_count(match_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // stimulus side
  item_t       pending_q[$];
  int unsigned items_queued = 0;
  int unsigned beats_in = 0;
  int unsigned counts_checked = 0;
  int unsigned settings_used = 0;
  int unsigned failures = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  logic [7:0]  qtext [QBYTES];
  int unsigned q_used = 0;

  // predictor state
  logic [QLEN_W-1:0] cfg_len;
  logic [63:0]       cfg_words [QWORDS];
  logic [7:0]        win [WIN_DEPTH];
  int unsigned       win_fill;
  bit                line_cut;
  logic [OUT_W-1:0]  log_total;
  logic [OUT_W-1:0]  expected_counts[$];

  function automatic bit token_sep(input logic [7:0] c);
    case (c)
      CH_NUL, CH_SPACE, CH_TAB, CH_COLON, CH_EQ, CH_COMMA, CH_LBRK, CH_RBRK: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] q_byte(input int k);
    if (k >= QBYTES) return 8'h00;
    return cfg_words[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic void clear_line();
    foreach (win[i]) win[i] = 8'h00;
    win_fill = 0;
    line_cut = 1'b0;
  endfunction

  // count an occurrence that ends at the newest window byte
  function automatic void close_token();
    int unsigned len;
    bit hit;
    len = (cfg_len > MAXQ) ? MAXQ : cfg_len;
    if (len == 0 || win_fill < len) return;
    if (win_fill > len && !token_sep(win[len])) return;
    hit = 1'b1;
    for (int j = 0; j < len; j++)
      if (win[len - 1 - j] != q_byte(j)) hit = 1'b0;
    if (hit && log_total != '1) log_total++;
  endfunction

  function automatic void log_beat(input logic is_end, input logic [7:0] b);
    if (is_end == OP_END) begin
      if (!line_cut) close_token();
      expected_counts.push_back(log_total);
      clear_line();
      log_total = '0;
      return;
    end
    if (b == CH_NL) begin
      if (!line_cut) close_token();
      clear_line();
      return;
    end
    if (line_cut) return;
    if (b == CH_NUL) begin
      close_token();
      line_cut = 1'b1;
      return;
    end
    if (token_sep(b)) close_token();
    for (int k = WIN_DEPTH - 1; k > 0; k--) win[k] = win[k - 1];
    win[0] = b;
    if (win_fill < WIN_DEPTH) win_fill++;
  endfunction

  task automatic flag(input string what, input logic [OUT_W-1:0] want,
                      input logic [OUT_W-1:0] got);
    failures++;
    if (failures <= 10)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        log_beat(op, data_byte);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          item_t nxt;
          nxt = pending_q.pop_front();
          in_valid  <= 1'b1;
          op        <= nxt.op;
          data_byte <= nxt.data_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        counts_checked++;
        if (expected_counts.size() == 0) begin
          flag("count with no log pending", '0, match_count);
        end else begin
          want = expected_counts.pop_front();
          if (match_count !== want) flag("match_count mismatch", want, match_count);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_QLEN:   cfg_len = val[QLEN_W-1:0];
      REG_QLOW:   cfg_words[0] = val;
      REG_QSEC:   cfg_words[1] = val;
      REG_QTHIRD: cfg_words[2] = val;
      REG_QHIGH:  cfg_words[3] = val;
      default: ;
    endcase
  endtask

  task automatic write_query(input int unsigned len_reg);
    logic [63:0] words [QWORDS];
    logic [63:0] len_word;
    for (int k = 0; k < QBYTES; k++) words[k / 8][8 * (k % 8) +: 8] = qtext[k];
    len_word = {$urandom, $urandom};
    if ($urandom_range(1) == 0) len_word = '0;
    len_word[QLEN_W-1:0] = len_reg[QLEN_W-1:0];
    apb_write(REG_QLEN, len_word);
    apb_write(REG_QLOW, words[0]);
    apb_write(REG_QSEC, words[1]);
    apb_write(REG_QTHIRD, words[2]);
    apb_write(REG_QHIGH, words[3]);
    q_used = (len_reg > MAXQ) ? MAXQ : len_reg;
    settings_used++;
  endtask

  function automatic logic [7:0] letter();
    return 8'h61 + 8'($urandom_range(2));
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(6))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_COLON;
      3: return CH_EQ;
      4: return CH_COMMA;
      5: return CH_LBRK;
      default: return CH_RBRK;
    endcase
  endfunction

  // kinds: empty, single byte, full width, oversize length, embedded
  // delimiters, embedded NUL or newline, random mid length
  task automatic set_query(input int kind);
    int unsigned len_reg;
    case (kind)
      0: len_reg = 0;
      1: len_reg = 1;
      2: len_reg = QBYTES;
      3: len_reg = $urandom_range(63, QBYTES + 1);
      6: len_reg = $urandom_range(31, 1);
      default: len_reg = $urandom_range(8, 3);
    endcase
    for (int k = 0; k < QBYTES; k++)
      qtext[k] = (k < len_reg) ? letter() : 8'($urandom_range(255));
    if (kind == 4) begin
      qtext[$urandom_range(len_reg - 2, 1)] = CH_COLON;
      if ($urandom_range(1)) qtext[$urandom_range(len_reg - 2, 1)] = CH_EQ;
    end
    if (kind == 5) qtext[$urandom_range(len_reg - 1)] = $urandom_range(1) ? CH_NUL : CH_NL;
    write_query(len_reg);
  endtask

  task automatic push_item(input logic is_end, input logic [7:0] b);
    item_t it;
    it.op = is_end;
    it.data_byte = b;
    pending_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(OP_BYTE, s[i]);
  endtask

  // mostly well-formed lines built from query copies and delimiters
  task automatic gen_logs(input int n);
    int unsigned stop_at;
    int r, cut, reps;
    logic [7:0] b;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      r = $urandom_range(99);
      if (r < 32) begin
        cut = q_used;
        if (cut > 1 && $urandom_range(7) == 0) cut = $urandom_range(cut - 1, 1);
        for (int k = 0; k < cut; k++) begin
          b = qtext[k];
          if ($urandom_range(24) == 0) b = b ^ 8'h02;
          push_item(OP_BYTE, b);
        end
        if (q_used == 0) push_item(OP_BYTE, letter());
      end else if (r < 56) begin
        push_item(OP_BYTE, sep_char());
      end else if (r < 70) begin
        reps = $urandom_range(3, 1);
        for (int k = 0; k < reps; k++) push_item(OP_BYTE, letter());
      end else if (r < 78) begin
        push_item(OP_BYTE, CH_NL);
      end else if (r < 81) begin
        push_item(OP_BYTE, CH_NUL);
      end else if (r < 93) begin
        push_item(OP_BYTE, 8'($urandom_range(255)));
      end else begin
        push_item(OP_END, 8'($urandom_range(255)));
      end
    end
    push_item(OP_END, 8'($urandom_range(255)));
  endtask

  // wait for every queued beat to be taken and every count to come back
  task automatic drain();
    while (beats_in != items_queued || expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cfg_len = '0;
    foreach (cfg_words[i]) cfg_words[i] = '0;
    foreach (qtext[i]) qtext[i] = 8'h00;
    clear_line();
    log_total = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle = 17;
    recv_idle = 71;
    // reset query is empty: nothing counts, byte on end-of-log ignored
    push_text("x");
    push_item(OP_END, 8'hFF);
    drain();
    qtext[0] = "a";
    qtext[1] = CH_COLON;
    qtext[2] = "a";
    write_query(3);
    // overlapping hits, bracket bounds, then a NUL cutting the line short
    push_text("a:a:a\n[a:a]");
    push_item(OP_END, 8'h00);
    push_text("a:a");
    push_item(OP_BYTE, CH_NUL);
    push_text("a:a");
    push_item(OP_END, 8'h5A);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle = 17; recv_idle = 71; end
        1: begin send_idle = 71; recv_idle = 17; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int s = 0; s < 3; s++) begin
        set_query((mode * 3 + s) % 7);
        gen_logs(90);
        drain();
        gen_logs(100);
        drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (expected_counts.size() != 0) flag("counts never returned", '0, '0);
    $display("Checked %0d log counts from %0d input beats over %0d query settings,",
             counts_checked, beats_in, settings_used);
    $display("with empty, oversize and delimiter-bearing queries and NUL-cut lines.");
    if (failures == 0) begin
      $display("PASS token_bounded_match_counter_unit");
    end else begin
      $display("%0d failures", failures);
      $display("FAIL token_bounded_match_counter_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d counts outstanding", expected_counts.size());
    $display("FAIL token_bounded_match_counter_unit");
    $finish;
  end

endmodule
